// File: sv/pcrb_pkg.sv
// Shared types and constants for the postmortem capture ring buffer.
// No dependencies; the top level, front end and back end import this package.
`default_nettype none

package pcrb_pkg;

    // Default number of samples in the ring.
    localparam int unsigned RING_DEPTH = 1024;

    // Width of the reported write index.
    localparam int unsigned IDX_W = 10;

    // Saturation bounds of a signed Q16.16 value.
    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    // Operation codes on the input op field.
    localparam logic [2:0] OP_INSERT     = 3'd0;
    localparam logic [2:0] OP_IDLE       = 3'd1;
    localparam logic [2:0] OP_DISABLE    = 3'd2;
    localparam logic [2:0] OP_POSTMORTEM = 3'd3;
    localparam logic [2:0] OP_BUFFER     = 3'd4;
    localparam logic [2:0] OP_CLEAR      = 3'd5;
    localparam logic [2:0] OP_TEST       = 3'd6;

    typedef enum logic [1:0] {
        MODE_DISABLED   = 2'd0,
        MODE_IDLE       = 2'd1,
        MODE_BUFFERING  = 2'd2,
        MODE_POSTMORTEM = 2'd3
    } t_mode;

    // Command classes handed from the front end to the back end.
    typedef enum logic [2:0] {
        CMD_INSERT,
        CMD_SET_MODE,
        CMD_CLEAR,
        CMD_TEST,
        CMD_NOP
    } t_cmd_kind;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] sample;
        logic signed [31:0] ref_value;
        logic [30:0]        tolerance;
    } t_item;

    typedef struct packed {
        t_mode              mode;
        logic [IDX_W-1:0]   write_index;
        logic               out_of_limits;
    } t_result;

    typedef struct packed {
        t_cmd_kind          kind;
        t_mode              mode;
        logic signed [31:0] sample;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
    } t_cmd;

endpackage

`default_nettype wire

// File: sv/postmortem_capture_ring_buffer.sv
// Postmortem capture ring buffer, top level. Uses pcrb_pkg, pcrb_front, pcrb_fifo, pcrb_back.
// Inserts, mode changes and unused codes: one per cycle while neither queue is full and the back
// end is idle; each result reaches the ports through the command queue, then the result queue.
// Clear and limit test walk the sample memory one entry a cycle; a test stops at the first failure.
// Synchronous active-low reset; then a zeroing pass over the sample memory holds full high.
`default_nettype none

module postmortem_capture_ring_buffer #(
    parameter int unsigned DEPTH = pcrb_pkg::RING_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire pcrb_pkg::t_item   i_item,
    output logic                   empty,
    input  wire logic              pop,
    output pcrb_pkg::t_result      o_result
);

    import pcrb_pkg::*;

    // Command path between the front end and the back end.
    logic    w_cmd_full;
    logic    w_cmd_empty;
    logic    w_cmd_push;
    logic    w_cmd_pop;
    t_cmd    w_cmd_in;
    t_cmd    w_cmd_out;
    logic    w_init_busy;

    // Result path from the back end to the output queue.
    logic    w_res_push;
    logic    w_res_full;
    t_result w_res;

    // The front end decodes each transfer and saturates the limit band once,
    // so the back end only compares.
    pcrb_front u_front (
        .i_push      (push),
        .i_item      (i_item),
        .o_full      (full),
        .i_cmd_full  (w_cmd_full),
        .i_init_busy (w_init_busy),
        .o_cmd_push  (w_cmd_push),
        .o_cmd       (w_cmd_in)
    );

    // Two-entry command queue: inserts flow at full rate while the back end
    // is free, and stall cleanly during a clear or a scan.
    pcrb_fifo #(
        .WIDTH      ($bits(t_cmd)),
        .DEPTH_LOG2 (1)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_wdata (w_cmd_in),
        .o_full  (w_cmd_full),
        .i_pop   (w_cmd_pop),
        .o_rdata (w_cmd_out),
        .o_empty (w_cmd_empty)
    );

    // The back end owns all state; it takes a command only when the result
    // queue has room, so a command is never half done.
    pcrb_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd_out),
        .i_cmd_empty (w_cmd_empty),
        .o_cmd_pop   (w_cmd_pop),
        .o_res_push  (w_res_push),
        .o_res       (w_res),
        .i_res_full  (w_res_full),
        .o_init_busy (w_init_busy)
    );

    // Two-entry result queue decouples the consumer from the back end.
    pcrb_fifo #(
        .WIDTH      ($bits(t_result)),
        .DEPTH_LOG2 (1)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_wdata (w_res),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_rdata (o_result),
        .o_empty (empty)
    );

endmodule

`default_nettype wire

// File: sv/pcrb_fifo.sv
// Small first-in first-out queue of generic width, used for commands and results.
// Self-contained; depends on no package.
`default_nettype none

module pcrb_fifo #(
    parameter int unsigned WIDTH      = 8,
    parameter int unsigned DEPTH_LOG2 = 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_rdata,
    output logic                  o_empty
);

    localparam int unsigned Entries = 2 ** DEPTH_LOG2;

    logic [WIDTH-1:0]      r_mem [Entries];
    logic [DEPTH_LOG2-1:0] r_wr_ptr;
    logic [DEPTH_LOG2-1:0] r_rd_ptr;
    logic [DEPTH_LOG2:0]   r_count;
    logic                  w_do_push;
    logic                  w_do_pop;

    assign o_full    = (r_count == (DEPTH_LOG2 + 1)'(Entries));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push & ~o_full;
    assign w_do_pop  = i_pop & ~o_empty;
    assign o_rdata   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: sv/pcrb_front.sv
// Front end: accepts input items, decodes the operation and precomputes the
// saturated limit band. Depends on pcrb_pkg.
`default_nettype none

module pcrb_front (
    input  wire logic            i_push,
    input  wire pcrb_pkg::t_item i_item,
    output logic                 o_full,
    input  wire logic            i_cmd_full,
    input  wire logic            i_init_busy,
    output logic                 o_cmd_push,
    output pcrb_pkg::t_cmd       o_cmd
);

    import pcrb_pkg::*;

    logic signed [32:0] w_ref_x;
    logic signed [32:0] w_tol_x;
    logic signed [32:0] w_hi_sum;
    logic signed [32:0] w_lo_sum;

    function automatic logic signed [31:0] sat_q(input logic signed [32:0] v);
        logic signed [31:0] res;
        if (v[32] != v[31]) begin
            res = v[32] ? Q_MIN : Q_MAX;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    // Nothing is taken while the queue is full or the store is being cleared after reset.
    assign o_full     = i_cmd_full | i_init_busy;
    assign o_cmd_push = i_push & ~o_full;

    assign w_ref_x  = {i_item.ref_value[31], i_item.ref_value};
    assign w_tol_x  = {2'b00, i_item.tolerance};
    assign w_hi_sum = w_ref_x + w_tol_x;
    assign w_lo_sum = w_ref_x - w_tol_x;

    always_comb begin
        o_cmd.kind   = CMD_NOP;
        o_cmd.mode   = MODE_DISABLED;
        o_cmd.sample = i_item.sample;
        o_cmd.lo     = sat_q(w_lo_sum);
        o_cmd.hi     = sat_q(w_hi_sum);
        case (i_item.op)
            OP_INSERT: begin
                o_cmd.kind = CMD_INSERT;
            end
            OP_IDLE: begin
                o_cmd.kind = CMD_SET_MODE;
                o_cmd.mode = MODE_IDLE;
            end
            OP_DISABLE: begin
                o_cmd.kind = CMD_SET_MODE;
                o_cmd.mode = MODE_DISABLED;
            end
            OP_POSTMORTEM: begin
                o_cmd.kind = CMD_SET_MODE;
                o_cmd.mode = MODE_POSTMORTEM;
            end
            OP_BUFFER: begin
                o_cmd.kind = CMD_SET_MODE;
                o_cmd.mode = MODE_BUFFERING;
            end
            OP_CLEAR: begin
                o_cmd.kind = CMD_CLEAR;
            end
            OP_TEST: begin
                o_cmd.kind = CMD_TEST;
            end
            default: begin
                o_cmd.kind = CMD_NOP;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sv/pcrb_back.sv
// Back end: owns the sample memory, write position and capture mode, and
// runs inserts, mode changes, clear sweeps and limit scans. Depends on pcrb_pkg.
`default_nettype none

module pcrb_back #(
    parameter int unsigned DEPTH = pcrb_pkg::RING_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire pcrb_pkg::t_cmd i_cmd,
    input  wire logic           i_cmd_empty,
    output logic                o_cmd_pop,
    output logic                o_res_push,
    output pcrb_pkg::t_result   o_res,
    input  wire logic           i_res_full,
    output logic                o_init_busy
);

    import pcrb_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam logic [AW-1:0] Last = AW'(DEPTH - 1);

    typedef enum logic [2:0] {
        S_INIT,
        S_RUN,
        S_CLEAR,
        S_SCAN,
        S_REPLY
    } t_state;

    t_state             r_state;
    t_mode              r_mode;
    t_mode              n_mode;
    logic [AW-1:0]      r_pos;
    logic [AW-1:0]      n_pos;
    logic [AW-1:0]      r_addr;
    logic               r_flag;
    logic               r_issue;
    logic               r_rd_vld;
    logic               r_rd_last;
    logic signed [31:0] r_lo;
    logic signed [31:0] r_hi;
    logic signed [31:0] r_rd_data;
    logic signed [31:0] r_mem [DEPTH];

    logic               w_mem_we;
    logic [AW-1:0]      w_mem_waddr;
    logic signed [31:0] w_mem_wdata;
    logic               w_outside;

    assign o_init_busy = (r_state == S_INIT);
    assign w_outside   = (r_rd_data < r_lo) || (r_rd_data > r_hi);

    always_comb begin
        n_mode      = r_mode;
        n_pos       = r_pos;
        w_mem_we    = 1'b0;
        w_mem_waddr = r_pos;
        w_mem_wdata = i_cmd.sample;
        o_cmd_pop   = 1'b0;
        o_res_push  = 1'b0;
        case (r_state)
            S_RUN: begin
                if (!i_cmd_empty && !i_res_full) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.kind)
                        CMD_INSERT: begin
                            o_res_push = 1'b1;
                            if (r_mode == MODE_BUFFERING || r_mode == MODE_POSTMORTEM) begin
                                w_mem_we = 1'b1;
                                if (r_pos == Last) begin
                                    n_pos = '0;
                                    if (r_mode == MODE_POSTMORTEM) begin
                                        n_mode = MODE_DISABLED;
                                    end
                                end else begin
                                    n_pos = r_pos + 1'b1;
                                end
                            end
                        end
                        CMD_SET_MODE: begin
                            o_res_push = 1'b1;
                            n_mode     = i_cmd.mode;
                        end
                        CMD_CLEAR: begin
                            n_mode = MODE_DISABLED;
                            n_pos  = '0;
                        end
                        CMD_TEST: begin
                            n_pos = '0;
                        end
                        default: begin
                            o_res_push = 1'b1;
                        end
                    endcase
                end
            end
            S_INIT, S_CLEAR: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = r_addr;
                w_mem_wdata = '0;
            end
            S_REPLY: begin
                o_res_push = ~i_res_full;
            end
            default: begin
                o_res_push = 1'b0;
            end
        endcase
        o_res.mode          = n_mode;
        o_res.write_index   = IDX_W'(n_pos);
        o_res.out_of_limits = (r_state == S_REPLY) & r_flag;
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_waddr] <= w_mem_wdata;
        end
        r_rd_data <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_mode    <= MODE_DISABLED;
            r_pos     <= '0;
            r_addr    <= '0;
            r_flag    <= 1'b0;
            r_issue   <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_rd_last <= 1'b0;
        end else begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_rd_vld <= 1'b0;
            case (r_state)
                S_INIT, S_CLEAR: begin
                    if (r_addr == Last) begin
                        r_addr  <= '0;
                        r_state <= (r_state == S_INIT) ? S_RUN : S_REPLY;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_RUN: begin
                    if (o_cmd_pop) begin
                        case (i_cmd.kind)
                            CMD_CLEAR: begin
                                r_state <= S_CLEAR;
                                r_addr  <= '0;
                                r_flag  <= 1'b0;
                            end
                            CMD_TEST: begin
                                r_state <= S_SCAN;
                                r_addr  <= '0;
                                r_flag  <= 1'b0;
                                r_issue <= 1'b1;
                                r_lo    <= i_cmd.lo;
                                r_hi    <= i_cmd.hi;
                            end
                            default: begin
                                r_state <= S_RUN;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    // Read address runs in the cycle before its compare, through the registered read data.
                    if (r_issue) begin
                        r_rd_vld  <= 1'b1;
                        r_rd_last <= (r_addr == Last);
                        if (r_addr == Last) begin
                            r_issue <= 1'b0;
                            r_addr  <= '0;
                        end else begin
                            r_addr <= r_addr + 1'b1;
                        end
                    end
                    if (r_rd_vld && (w_outside || r_rd_last)) begin
                        r_flag   <= w_outside;
                        r_state  <= S_REPLY;
                        r_issue  <= 1'b0;
                        r_addr   <= '0;
                        r_rd_vld <= 1'b0;
                    end
                end
                S_REPLY: begin
                    if (!i_res_full) begin
                        r_state <= S_RUN;
                    end
                end
                default: begin
                    r_state <= S_RUN;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
